// ===== rtl/pcg_pkg.sv =====
// ----------------------------------------------------------------------------
// pcg_pkg
// Shared types, constants and the output permutation of the 32-bit
// permuted congruential generator.
// ----------------------------------------------------------------------------
package pcg_pkg;

	// lcg multiplier and its 32-bit halves
	localparam logic [63:0] LCG_MULT    = 64'd6364136223846793005;
	localparam logic [31:0] LCG_MULT_LO = LCG_MULT[31:0];
	localparam logic [31:0] LCG_MULT_HI = LCG_MULT[63:32];

	// register reset values
	localparam logic [63:0] RESET_SEED   = 64'd42;
	localparam logic [62:0] RESET_STREAM = 63'd0;

	// state after the seeding sequence with seed 42 on stream 0
	localparam logic [63:0] RESET_STATE = 64'd15403440593478376592;

	// configuration register indexes
	localparam logic REG_SEED   = 1'b0;
	localparam logic REG_STREAM = 1'b1;

	// request codes
	typedef enum logic [1:0] {
		OP_RAW    = 2'd0,
		OP_RANGED = 2'd1,
		OP_BOOL   = 2'd2,
		OP_RESEED = 2'd3
	} op_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} seq_state_t;

	// xorshift high, then random rotate, of the old state
	function automatic logic [31:0] xsh_rr(input logic [63:0] s);
		logic [63:0] t;
		logic [31:0] m;
		logic [4:0]  r;
		t = (s >> 18) ^ s;
		m = t[58:27];
		r = s[63:59];
		return (m >> r) | (m << 5'(5'd0 - r));
	endfunction

endpackage

// ===== rtl/pcg32_random_generator_top.sv =====
// ----------------------------------------------------------------------------
// pcg32_random_generator_top
// 32-bit permuted congruential generator (xorshift-high, random rotate) with
// raw, ranged, boolean and reseed requests under a small sequencer.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid, in_stall, op, range_*           | request beat in
//   out     | out_valid, out_stall, value               | result beat out
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register write in
//
// Raw, boolean and reseed requests raise out_valid after the 64-bit lcg step,
// done as three 32x32 partial products on one shared multiplier. Ranged
// requests add the bit-serial remainder after that step; empty or full-width
// ranges skip both units and go straight to the done state.
// The next request is taken in the cycle after the result is loaded, so only
// one request is in flight at a time. Reset loads the seeded state directly.
// A result held by out_stall keeps the sequencer, and so the input, waiting.
// ----------------------------------------------------------------------------
module pcg32_random_generator_top
	import pcg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [31:0] range_low,
	input  logic [31:0] range_high,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] value,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data
);

	seq_state_t  state_q;
	seq_state_t  state_d;
	logic [63:0] seed_q;
	logic [62:0] stream_q;
	logic [63:0] lcg_q;
	op_t         op_q;
	logic [31:0] lo_q;
	logic [31:0] span_q;
	logic [31:0] raw_q;
	logic [31:0] res_q;
	logic [31:0] value_q;
	logic        out_valid_q;

	logic        in_acc;
	logic        out_free;
	logic [63:0] inc;
	logic [31:0] span_c;
	logic        trivial_c;
	logic        mul_start;
	logic [63:0] mul_a;
	logic        mul_done;
	logic [63:0] mul_res;
	logic        div_start;
	logic        div_done;
	logic [31:0] div_rem;

	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign inc       = {stream_q, 1'b1};
	assign span_c    = range_high - range_low + 32'd1;
	assign trivial_c = (range_low > range_high) || (span_c == 32'd0);
	assign mul_a     = (op_t'(op) == OP_RESEED) ? (inc + seed_q) : lcg_q;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q   <= RESET_SEED;
			stream_q <= RESET_STREAM;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SEED:   seed_q   <= cfg_data;
				REG_STREAM: stream_q <= cfg_data[62:0];
				default:    ;
			endcase
		end
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and unit starts
	always_comb begin
		state_d   = state_q;
		mul_start = 1'b0;
		div_start = 1'b0;
		in_stall  = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (op_t'(op) == OP_RANGED && trivial_c) begin
						state_d = ST_DONE;
					end else begin
						mul_start = 1'b1;
						state_d   = ST_MUL;
					end
				end
			end
			ST_MUL: begin
				if (mul_done) begin
					if (op_q == OP_RANGED) begin
						div_start = 1'b1;
						state_d   = ST_DIV;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// generator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcg_q <= RESET_STATE;
		end else if (state_q == ST_MUL && mul_done) begin
			lcg_q <= mul_res;
		end
	end

	// request fields and result
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q   <= op_t'(op);
			lo_q   <= range_low;
			span_q <= span_c;
			raw_q  <= xsh_rr(lcg_q);
			res_q  <= range_low;
		end else if (state_q == ST_MUL && mul_done) begin
			case (op_q)
				OP_RAW:  res_q <= raw_q;
				OP_BOOL: res_q <= {31'd0, raw_q[0]};
				default: res_q <= '0;
			endcase
		end else if (state_q == ST_DIV && div_done) begin
			res_q <= lo_q + div_rem;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			value_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;

	// shared lcg step unit
	pcg_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.op_a   (mul_a),
		.addend (inc),
		.done   (mul_done),
		.result (mul_res)
	);

	// bit-serial remainder unit
	pcg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (raw_q),
		.divisor  (span_q),
		.done     (div_done),
		.rem      (div_rem)
	);

	// checks
	a_mul_done_in_mul: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> state_q == ST_MUL)
		else $error("multiplier finished outside of the step state");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("remainder unit finished outside of the divide state");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> in_stall)
		else $error("request taken while a previous one is in flight");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("result beat raised without a finished request");

endmodule

// ===== rtl/pcg_mul.sv =====
// ----------------------------------------------------------------------------
// pcg_mul
// Iterative lcg step: result = a * LCG_MULT + addend (mod 2^64), built from
// three 32x32 partial products through one shared multiplier.
// ----------------------------------------------------------------------------
module pcg_mul
	import pcg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] op_a,
	input  logic [63:0] addend,
	output logic        done,
	output logic [63:0] result
);

	logic [63:0] a_q;
	logic [63:0] acc_q;
	logic [1:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [63:0] prod_s1;
	logic        pv_s1;
	logic        psh_s1;

	logic [31:0] mx;
	logic [31:0] my;
	logic [63:0] prod_c;

	// operand select for the shared multiplier
	always_comb begin
		case (cnt_q)
			2'd0:    begin mx = a_q[31:0];  my = LCG_MULT_LO; end
			2'd1:    begin mx = a_q[31:0];  my = LCG_MULT_HI; end
			default: begin mx = a_q[63:32]; my = LCG_MULT_LO; end
		endcase
	end

	assign prod_c = mx * my;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			pv_s1  <= 1'b0;
			psh_s1 <= 1'b0;
		end else if (start) begin
			cnt_q  <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
			pv_s1  <= 1'b0;
		end else begin
			done_q <= pv_s1 && !busy_q;
			pv_s1  <= busy_q;
			psh_s1 <= (cnt_q != 2'd0);
			if (busy_q) begin
				if (cnt_q == 2'd2) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + 2'd1;
				end
			end
		end
	end

	// operands, product register and accumulator
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= op_a;
			acc_q <= addend;
		end else if (pv_s1) begin
			acc_q <= acc_q + (psh_s1 ? {prod_s1[31:0], 32'd0} : prod_s1);
		end
		prod_s1 <= prod_c;
	end

	assign done   = done_q;
	assign result = acc_q;

endmodule

// ===== rtl/pcg_div.sv =====
// ----------------------------------------------------------------------------
// pcg_div
// Restoring bit-serial remainder of a 32-bit dividend by a nonzero 32-bit
// divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module pcg_div
	import pcg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] rem
);

	logic [31:0] dvd_q;
	logic [31:0] dsr_q;
	logic [31:0] rem_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;

	logic [32:0] trial;
	logic [32:0] diff;

	// shift in the next dividend bit and try a subtract
	assign trial = {rem_q, dvd_q[31]};
	assign diff  = trial - {1'b0, dsr_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == 5'd31);
			if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			rem_q <= diff[32] ? trial[31:0] : diff[31:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

// ===== tb/tb_pcg32_random_generator_top.sv =====
// ----------------------------------------------------------------------------
// tb_pcg32_random_generator_top
// Self-checking bench for the pcg32 generator. A queue-fed driver sends
// raw, ranged, boolean and reseed requests under random idle bursts. A
// monitor keeps its own lcg state and register copies, predicts each result
// word and compares every output beat in order. Directed corner requests
// come first, then random phases under several seed and stream settings.
// ----------------------------------------------------------------------------
module tb_pcg32_random_generator_top;
	import pcg_pkg::*;

	localparam int CLK_HALF     = 5;
	localparam int SETTLE_WAIT  = 8;
	localparam int PHASE_ITEMS  = 300;
	localparam int SHOW_LIMIT   = 40;
	localparam logic [63:0] BOOT_SEED = 64'd42;

	typedef struct packed {
		op_t         kind;
		logic [31:0] lo;
		logic [31:0] hi;
	} pcg_req_t;

	// dut ports
	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        in_valid   = 1'b0;
	logic        in_stall;
	logic [1:0]  op         = OP_RAW;
	logic [31:0] range_low  = '0;
	logic [31:0] range_high = '0;
	logic        out_valid;
	logic        out_stall  = 1'b0;
	logic [31:0] value;
	logic        cfg_valid  = 1'b0;
	logic        cfg_ready;
	logic        cfg_index  = REG_SEED;
	logic [63:0] cfg_data   = '0;

	// request queue and expected result words
	pcg_req_t    pending_reqs[$];
	logic [31:0] expected_words[$];
	pcg_req_t    drv_req;

	// generator model
	logic [63:0] lcg_model;
	logic [63:0] seed_model;
	logic [62:0] stream_model;

	// idle control
	int in_idle_pct  = 0;
	int out_idle_pct = 0;
	int in_gap       = 0;
	int out_gap      = 0;

	// bookkeeping
	int items_sent     = 0;
	int results_seen   = 0;
	int mismatch_count = 0;
	int reg_writes     = 0;
	int degenerate_cnt = 0;
	int op_seen[4]     = '{default: 0};

	pcg32_random_generator_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.range_low  (range_low),
		.range_high (range_high),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.value      (value),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// clock
	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// ---------------- generator model ----------------

	function automatic void step_lcg();
		lcg_model = lcg_model * LCG_MULT + {stream_model, 1'b1};
	endfunction

	function automatic void reseed_lcg();
		lcg_model = '0;
		step_lcg();
		lcg_model = lcg_model + seed_model;
		step_lcg();
	endfunction

	// xorshift-high of the old state, rotate right by its top five bits
	function automatic logic [31:0] draw_word();
		logic [63:0] prev;
		logic [63:0] mixed;
		logic [31:0] folded;
		logic [4:0]  rot;
		logic [63:0] doubled;
		prev    = lcg_model;
		mixed   = (prev >> 18) ^ prev;
		folded  = mixed[58:27];
		rot     = prev[63:59];
		doubled = {folded, folded} >> rot;
		step_lcg();
		return doubled[31:0];
	endfunction

	function automatic logic [31:0] predict_word(op_t kind, logic [31:0] lo, logic [31:0] hi);
		logic [31:0] span;
		logic [31:0] w;
		span = hi - lo + 32'd1;
		case (kind)
			OP_RAW: begin
				return draw_word();
			end
			OP_RANGED: begin
				// empty or full-width range returns the low bound, no advance
				if (lo > hi || span == 32'd0)
					return lo;
				w = draw_word();
				return lo + (w % span);
			end
			OP_BOOL: begin
				w = draw_word();
				return {31'd0, w[0]};
			end
			default: begin
				reseed_lcg();
				return 32'd0;
			end
		endcase
	endfunction

	// ---------------- checking ----------------

	task automatic report_mismatch(input string what);
		if (mismatch_count < SHOW_LIMIT)
			$display("[%0t] mismatch: %s", $realtime, what);
		mismatch_count++;
	endtask

	// output beats checked first, then the accepted request is predicted
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (expected_words.size() == 0) begin
					report_mismatch($sformatf("result beat %h with nothing expected", value));
				end else begin
					if (value !== expected_words[0])
						report_mismatch($sformatf("value %h, expected %h",
							value, expected_words[0]));
					void'(expected_words.pop_front());
				end
			end
			if (in_valid && !in_stall) begin
				op_seen[op]++;
				if (op_t'(op) == OP_RANGED &&
					(range_low > range_high || (range_low == 0 && range_high == '1)))
					degenerate_cnt++;
				expected_words.push_back(predict_word(op_t'(op), range_low, range_high));
			end
			// register writes must only land while the generator is idle; the dut does not enforce it
			if (cfg_valid && cfg_ready) begin
				reg_writes++;
				if (cfg_index == REG_SEED)
					seed_model = cfg_data;
				else
					stream_model = cfg_data[62:0];
			end
		end
	end

	// ---------------- driving ----------------

	// request driver with random idle bursts
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (in_gap != 0) begin
				in_gap   <= in_gap - 1;
				in_valid <= 1'b0;
			end else if (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
				in_gap   <= $urandom_range(4);
				in_valid <= 1'b0;
			end else if (pending_reqs.size() != 0) begin
				drv_req    = pending_reqs.pop_front();
				op         <= drv_req.kind;
				range_low  <= drv_req.lo;
				range_high <= drv_req.hi;
				in_valid   <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result side stall bursts
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (out_gap != 0) begin
			out_gap   <= out_gap - 1;
			out_stall <= 1'b1;
		end else if (out_idle_pct != 0 && $urandom_range(99) < out_idle_pct) begin
			out_gap   <= $urandom_range(4);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// ---------------- stimulus ----------------

	task automatic send(input op_t kind, input logic [31:0] lo, input logic [31:0] hi);
		pending_reqs.push_back('{kind: kind, lo: lo, hi: hi});
		items_sent++;
	endtask

	function automatic pcg_req_t random_request();
		pcg_req_t r;
		int pick;
		pick = $urandom_range(99);
		r.lo = $urandom;
		r.hi = $urandom;
		if (pick < 35) begin
			r.kind = OP_RAW;
		end else if (pick < 70) begin
			r.kind = OP_RANGED;
			case ($urandom_range(5))
				0: ;
				1: r.hi = r.lo + $urandom_range(15);
				2: begin
					r.lo = $urandom_range(1000);
					r.hi = r.lo + (32'd1 << $urandom_range(31)) - 32'd1;
				end
				3: begin
					r.lo = '0;
					if ($urandom_range(1))
						r.hi = '1;
				end
				4: r.hi = r.lo;
				default: r.lo = r.hi + 32'd1;
			endcase
		end else if (pick < 90) begin
			r.kind = OP_BOOL;
		end else begin
			r.kind = OP_RESEED;
		end
		return r;
	endfunction

	task automatic queue_random(input int count);
		repeat (count) begin
			pending_reqs.push_back(random_request());
			items_sent++;
		end
	endtask

	// wait until every result has come back, then let the sequencer settle
	task automatic drain_all();
		while (results_seen != items_sent)
			@(posedge clk);
		repeat (SETTLE_WAIT) @(posedge clk);
	endtask

	task automatic write_register(input logic idx, input logic [63:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
	endtask

	task automatic set_idling(input int in_pct, input int out_pct);
		in_idle_pct  = in_pct;
		out_idle_pct = out_pct;
	endtask

	initial begin
		seed_model   = BOOT_SEED;
		stream_model = '0;
		reseed_lcg();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed corners on the reset settings
		set_idling(0, 0);
		send(OP_RAW, '0, '0);
		send(OP_RAW, '1, '1);
		send(OP_BOOL, '0, '0);
		send(OP_BOOL, '1, '1);
		send(OP_RANGED, 32'd0, 32'd0);
		send(OP_RANGED, 32'd0, 32'd1);
		send(OP_RANGED, 32'd0, '1);
		send(OP_RANGED, '1, '1);
		send(OP_RANGED, 32'd5, 32'd4);
		send(OP_RANGED, '1, 32'd0);
		send(OP_RANGED, 32'd1, '1);
		send(OP_RANGED, 32'hFFFF_FFFE, '1);
		send(OP_RANGED, 32'h8000_0000, 32'h8000_0006);
		send(OP_RANGED, 32'd0, 32'hFFFF_FFFE);
		send(OP_RESEED, '1, '0);
		send(OP_RAW, '0, '1);
		send(OP_RANGED, 32'd100, 32'd199);
		send(OP_BOOL, 32'h5555_5555, 32'hAAAA_AAAA);
		drain_all();

		// extreme register values
		write_register(REG_SEED, '1);
		write_register(REG_STREAM, {1'b0, {63{1'b1}}});
		send(OP_RAW, '0, '0);
		send(OP_RESEED, '0, '0);
		send(OP_RAW, '0, '0);
		send(OP_RANGED, 32'd10, 32'd20);
		send(OP_BOOL, '0, '0);
		set_idling(30, 30);
		queue_random(PHASE_ITEMS);
		drain_all();

		write_register(REG_SEED, '0);
		write_register(REG_STREAM, '0);
		set_idling(0, 50);
		queue_random(PHASE_ITEMS);
		drain_all();

		// sender holds off mid-phase until everything is back
		write_register(REG_SEED, {$urandom, $urandom});
		write_register(REG_STREAM, {1'b0, 31'($urandom), $urandom});
		set_idling(50, 0);
		queue_random(PHASE_ITEMS / 2);
		drain_all();
		queue_random(PHASE_ITEMS / 2);
		drain_all();

		write_register(REG_SEED, BOOT_SEED);
		write_register(REG_STREAM, 64'd1);
		set_idling(20, 20);
		queue_random(PHASE_ITEMS);
		drain_all();

		write_register(REG_STREAM, {1'b0, 31'($urandom), $urandom});
		write_register(REG_SEED, {$urandom, $urandom});
		set_idling(10, 60);
		queue_random(PHASE_ITEMS);
		drain_all();

		// closing stretch at full rate
		write_register(REG_STREAM, {1'b0, 31'($urandom), $urandom});
		set_idling(0, 0);
		queue_random(PHASE_ITEMS);
		drain_all();
		repeat (20) @(posedge clk);

		if (expected_words.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_words.size()));
		$display("covered %0d raw, %0d ranged (%0d empty or full-width), %0d boolean, %0d reseed",
			op_seen[OP_RAW], op_seen[OP_RANGED], degenerate_cnt,
			op_seen[OP_BOOL], op_seen[OP_RESEED]);
		$display("%0d results checked across %0d register writes, %0d mismatches",
			results_seen, reg_writes, mismatch_count);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// watchdog
	initial begin
		#6000000;
		$display("timeout: %0d of %0d results seen", results_seen, items_sent);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/pcg_pkg.sv
rtl/pcg_mul.sv
rtl/pcg_div.sv
rtl/pcg32_random_generator_top.sv
tb/tb_pcg32_random_generator_top.sv
